### rtl/nat_pkg.sv
// Shared types and codes for the neighbour address table.
package nat_pkg;

    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_REM_DEV = 2'd2;
    localparam logic [1:0] CMD_LOOKUP  = 2'd3;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_EXISTS   = 3'd1;
    localparam logic [2:0] STAT_BADLEN   = 3'd2;
    localparam logic [2:0] STAT_FULL     = 3'd3;
    localparam logic [2:0] STAT_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [7:0] dev;
        logic [7:0] endpoint;
        logic       origin;
    } nat_key_t;

endpackage

### rtl/nat_store.sv
// Entry storage: valid-bit memory and key/address memory, with a registered read port.
module nat_store #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDR_BYTES    = 8,
    parameter int IDX_W         = 4
) (
    input  logic                    aclk,
    input  logic                    rd_en,
    input  logic [IDX_W-1:0]        rd_idx,
    output logic                    rd_valid,
    output nat_pkg::nat_key_t       rd_key,
    output logic [8*ADDR_BYTES-1:0] rd_addr,
    input  logic                    vwr_en,
    input  logic [IDX_W-1:0]        vwr_idx,
    input  logic                    vwr_val,
    input  logic                    dwr_en,
    input  logic [IDX_W-1:0]        dwr_idx,
    input  nat_pkg::nat_key_t       dwr_key,
    input  logic [8*ADDR_BYTES-1:0] dwr_addr
);

    localparam int ADDR_W = 8 * ADDR_BYTES;
    localparam int KEY_W  = $bits(nat_pkg::nat_key_t);
    localparam int DW     = KEY_W + ADDR_W;

    logic          valid_mem [TABLE_ENTRIES];
    logic [DW-1:0] data_mem  [TABLE_ENTRIES];
    logic          valid_rd_reg;
    logic [DW-1:0] data_rd_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            valid_rd_reg <= valid_mem[rd_idx];
            data_rd_reg  <= data_mem[rd_idx];
        end
        if (vwr_en) begin
            valid_mem[vwr_idx] <= vwr_val;
        end
        if (dwr_en) begin
            data_mem[dwr_idx] <= {dwr_key, dwr_addr};
        end
    end

    assign rd_valid = valid_rd_reg;
    assign rd_key   = nat_pkg::nat_key_t'(data_rd_reg[DW-1:ADDR_W]);
    assign rd_addr  = data_rd_reg[ADDR_W-1:0];

endmodule

### rtl/neighbour_address_table.sv
// Neighbour address table top level: command sequencer, scan logic and result register.
// Each command word is answered by one result word. A command scans every table entry
// through the one read port of the entry memory, one entry per cycle, and then writes back
// and loads the result in the finish state, which holds while the previous result is unread.
// After reset the valid-bit memory is cleared one entry per cycle, and s_ready stays low
// until that clearing pass is done. A new command is accepted while the previous result
// still waits on m_ready.
module neighbour_address_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDR_BYTES    = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_dev_id,
    input  logic [7:0]  s_endpoint,
    input  logic        s_origin_kind,
    input  logic [3:0]  s_addr_len,
    input  logic [63:0] s_hw_addr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [63:0] m_hw_addr_out
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W = 8 * ADDR_BYTES;

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;

    logic [1:0]        cmd_reg;
    nat_pkg::nat_key_t key_reg;
    logic              len_bad_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic              found_reg, found_next;
    logic              dropped_reg, dropped_next;
    logic              free_reg, free_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [ADDR_W-1:0] hit_addr_reg, hit_addr_next;

    logic              m_valid_reg, m_valid_next;
    logic [2:0]        status_reg;
    logic [63:0]       hw_out_reg;

    logic              rd_en;
    logic              rd_valid;
    nat_pkg::nat_key_t rd_key;
    logic [ADDR_W-1:0] rd_addr;
    logic              vwr_en, vwr_val;
    logic [IDX_W-1:0]  vwr_idx;
    logic              dwr_en;

    logic              accept, issue, finish_go, add_ok;
    logic              pair_hit, full_hit, dev_hit;
    logic [63:0]       masked_addr;
    logic [2:0]        status_next;

    nat_store #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .ADDR_BYTES   (ADDR_BYTES),
        .IDX_W        (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_idx  (cnt_reg[IDX_W-1:0]),
        .rd_valid(rd_valid),
        .rd_key  (rd_key),
        .rd_addr (rd_addr),
        .vwr_en  (vwr_en),
        .vwr_idx (vwr_idx),
        .vwr_val (vwr_val),
        .dwr_en  (dwr_en),
        .dwr_idx (free_idx_reg),
        .dwr_key (key_reg),
        .dwr_addr(addr_reg)
    );

    assign accept    = s_valid && s_ready;
    assign issue     = (state_reg == S_SCAN) && (cnt_reg != CNT_W'(TABLE_ENTRIES));
    assign rd_en     = issue;
    assign finish_go = (state_reg == S_FINISH) && (!m_valid_reg || m_ready);

    assign pair_hit = cmp_vld_reg && rd_valid && (rd_key.dev == key_reg.dev)
                      && (rd_key.endpoint == key_reg.endpoint);
    assign full_hit = pair_hit && (rd_key.origin == key_reg.origin);
    assign dev_hit  = cmp_vld_reg && rd_valid && (rd_key.dev == key_reg.dev);

    assign add_ok = (cmd_reg == nat_pkg::CMD_ADD) && !found_reg && !len_bad_reg && free_reg;

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            masked_addr[8*b +: 8] = (4'(b) < s_addr_len) ? s_hw_addr[8*b +: 8] : 8'd0;
        end
    end

    always_comb begin
        vwr_en  = 1'b0;
        vwr_val = 1'b0;
        vwr_idx = cmp_idx_reg;
        dwr_en  = 1'b0;
        if (state_reg == S_CLEAR) begin
            vwr_en  = 1'b1;
            vwr_idx = cnt_reg[IDX_W-1:0];
        end else if (state_reg == S_SCAN) begin
            vwr_en = ((cmd_reg == nat_pkg::CMD_REMOVE) && full_hit)
                     || ((cmd_reg == nat_pkg::CMD_REM_DEV) && dev_hit);
        end else if (finish_go && add_ok) begin
            vwr_en  = 1'b1;
            vwr_val = 1'b1;
            vwr_idx = free_idx_reg;
            dwr_en  = 1'b1;
        end
    end

    always_comb begin
        case (cmd_reg)
            nat_pkg::CMD_ADD: begin
                if (found_reg)        status_next = nat_pkg::STAT_EXISTS;
                else if (len_bad_reg) status_next = nat_pkg::STAT_BADLEN;
                else if (!free_reg)   status_next = nat_pkg::STAT_FULL;
                else                  status_next = nat_pkg::STAT_OK;
            end
            nat_pkg::CMD_REMOVE:
                status_next = dropped_reg ? nat_pkg::STAT_OK : nat_pkg::STAT_NOTFOUND;
            nat_pkg::CMD_REM_DEV:
                status_next = nat_pkg::STAT_OK;
            default:
                status_next = found_reg ? nat_pkg::STAT_OK : nat_pkg::STAT_NOTFOUND;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cnt_reg[IDX_W-1:0];
        found_next    = found_reg;
        dropped_next  = dropped_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        hit_addr_next = hit_addr_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_CLEAR: begin
                if (cnt_reg == CNT_W'(TABLE_ENTRIES - 1)) begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next   = S_SCAN;
                    cnt_next     = '0;
                    found_next   = 1'b0;
                    dropped_next = 1'b0;
                    free_next    = 1'b0;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    cnt_next     = cnt_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end else begin
                    state_next = S_FINISH;
                end
                if (pair_hit && !found_reg) begin
                    found_next    = 1'b1;
                    hit_addr_next = rd_addr;
                end
                if (full_hit) begin
                    dropped_next = 1'b1;
                end
                if (cmp_vld_reg && !rd_valid && !free_reg) begin
                    free_next     = 1'b1;
                    free_idx_next = cmp_idx_reg;
                end
            end
            S_FINISH: begin
                if (finish_go) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg  <= cmp_idx_next;
        found_reg    <= found_next;
        dropped_reg  <= dropped_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        hit_addr_reg <= hit_addr_next;
        if (accept) begin
            cmd_reg      <= s_cmd;
            key_reg.dev      <= s_dev_id;
            key_reg.endpoint <= s_endpoint;
            key_reg.origin   <= s_origin_kind;
            len_bad_reg  <= s_addr_len > 4'(ADDR_BYTES);
            addr_reg     <= masked_addr[ADDR_W-1:0];
        end
        if (finish_go) begin
            status_reg <= status_next;
            hw_out_reg <= ((cmd_reg == nat_pkg::CMD_LOOKUP) && found_reg)
                          ? 64'(hit_addr_reg) : 64'd0;
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_hw_addr_out = hw_out_reg;

    // reset always starts the valid-bit clearing pass
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("command accepted before valid clear pass");

    a_add_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (dwr_en |-> (free_reg && !found_reg && vwr_val)))
        else $error("add written without a free slot");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg <= CNT_W'(TABLE_ENTRIES)))
        else $error("scan counter past table end");

    a_addr_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_hw_addr_out != 64'd0)) |-> (m_status == nat_pkg::STAT_OK))
        else $error("address returned with failing status");

endmodule

### sim/neighbour_address_table_test.sv
// Self-checking testbench for the neighbour address table: directed and random command words.
`timescale 1ns / 100ps

module neighbour_address_table_test;

    localparam int SLOTS      = 16;
    localparam int ADDR_BYTES = 8;
    localparam int QUIET_MAX  = 1000;
    localparam int PHASE_WORDS = 406;

    typedef struct {
        logic [2:0]  status;
        logic [63:0] hw_addr;
    } nat_reply_t;

    class nat_scoreboard;
        logic        slot_used [SLOTS];
        logic [7:0]  slot_dev [SLOTS];
        logic [7:0]  slot_endpoint [SLOTS];
        logic        slot_origin [SLOTS];
        logic [63:0] slot_addr [SLOTS];
        nat_reply_t  reply_q[$];
        int          fails;

        function new();
            fails = 0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i] = 1'b0;
            end
        endfunction

        function int pending();
            return reply_q.size();
        endfunction

        function void apply_command(logic [1:0] cmd, logic [7:0] dev, logic [7:0] ep,
                                    logic org, logic [3:0] len, logic [63:0] addr);
            nat_reply_t  r;
            int          hit;
            int          free_slot;
            bit          dropped;
            logic [63:0] kept;
            r.status  = nat_pkg::STAT_OK;
            r.hw_addr = '0;
            hit       = -1;
            free_slot = -1;
            dropped   = 1'b0;
            kept      = '0;
            for (int i = 0; i < SLOTS; i++) begin
                if (hit < 0 && slot_used[i] && slot_dev[i] == dev && slot_endpoint[i] == ep)
                    hit = i;
                if (free_slot < 0 && !slot_used[i])
                    free_slot = i;
            end
            case (cmd)
                nat_pkg::CMD_ADD: begin
                    if (hit >= 0) begin
                        r.status = nat_pkg::STAT_EXISTS;
                    end else if (int'(len) > ADDR_BYTES) begin
                        r.status = nat_pkg::STAT_BADLEN;
                    end else if (free_slot < 0) begin
                        r.status = nat_pkg::STAT_FULL;
                    end else begin
                        for (int b = 0; b < 8; b++) begin
                            if (b < int'(len))
                                kept[b*8 +: 8] = addr[b*8 +: 8];
                        end
                        slot_used[free_slot]     = 1'b1;
                        slot_dev[free_slot]      = dev;
                        slot_endpoint[free_slot] = ep;
                        slot_origin[free_slot]   = org;
                        slot_addr[free_slot]     = kept;
                    end
                end
                nat_pkg::CMD_REMOVE: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_used[i] && slot_dev[i] == dev && slot_endpoint[i] == ep &&
                            slot_origin[i] == org) begin
                            slot_used[i] = 1'b0;
                            dropped      = 1'b1;
                        end
                    end
                    if (!dropped)
                        r.status = nat_pkg::STAT_NOTFOUND;
                end
                nat_pkg::CMD_REM_DEV: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_used[i] && slot_dev[i] == dev)
                            slot_used[i] = 1'b0;
                    end
                end
                default: begin
                    if (hit >= 0)
                        r.hw_addr = slot_addr[hit];
                    else
                        r.status = nat_pkg::STAT_NOTFOUND;
                end
            endcase
            reply_q.push_back(r);
        endfunction

        function void check_reply(logic [2:0] status, logic [63:0] hw_addr);
            nat_reply_t want;
            if (reply_q.size() == 0) begin
                $error("result word with nothing expected: status %0d addr %h", status, hw_addr);
                fails++;
                return;
            end
            want = reply_q.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                fails++;
            end
            if (hw_addr !== want.hw_addr) begin
                $error("hw_addr_out: expected %h, got %h", want.hw_addr, hw_addr);
                fails++;
            end
        endfunction
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd         = nat_pkg::CMD_LOOKUP;
    logic [7:0]  s_dev_id      = '0;
    logic [7:0]  s_endpoint    = '0;
    logic        s_origin_kind = 1'b0;
    logic [3:0]  s_addr_len    = '0;
    logic [63:0] s_hw_addr     = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [2:0]  m_status;
    logic [63:0] m_hw_addr_out;

    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet     = 0;

    nat_scoreboard table_sb = new();

    neighbour_address_table #(
        .TABLE_ENTRIES(SLOTS),
        .ADDR_BYTES   (ADDR_BYTES)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_dev_id     (s_dev_id),
        .s_endpoint   (s_endpoint),
        .s_origin_kind(s_origin_kind),
        .s_addr_len   (s_addr_len),
        .s_hw_addr    (s_hw_addr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_hw_addr_out(m_hw_addr_out)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            table_sb.check_reply(m_status, m_hw_addr_out);
        if (aresetn && s_valid && s_ready)
            table_sb.apply_command(s_cmd, s_dev_id, s_endpoint, s_origin_kind, s_addr_len,
                                   s_hw_addr);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_MAX) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_command(input logic [1:0] cmd, input logic [7:0] dev,
                                input logic [7:0] ep, input logic org,
                                input logic [3:0] len, input logic [63:0] addr);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_dev_id      <= dev;
        s_endpoint    <= ep;
        s_origin_kind <= org;
        s_addr_len    <= len;
        s_hw_addr     <= addr;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_replies();
        s_valid <= 1'b0;
        do @(posedge aclk); while (table_sb.pending() != 0);
    endtask

    // keys come mostly from a small pool so adds collide and lookups hit
    task automatic send_random(input int n);
        logic [1:0] cmd;
        logic [7:0] dev;
        logic [7:0] ep;
        logic [3:0] len;
        int         r;
        int         add_weight;
        add_weight = ((n / 60) % 2 == 0) ? 60 : 30;
        r = $urandom_range(99);
        if (r < add_weight)
            cmd = nat_pkg::CMD_ADD;
        else if (r < add_weight + 15)
            cmd = nat_pkg::CMD_REMOVE;
        else if (r < add_weight + 19)
            cmd = nat_pkg::CMD_REM_DEV;
        else
            cmd = nat_pkg::CMD_LOOKUP;
        dev = ($urandom_range(99) < 85) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        ep  = ($urandom_range(99) < 85) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
        len = ($urandom_range(99) < 85) ? 4'($urandom_range(8)) : 4'($urandom_range(15, 9));
        send_command(cmd, dev, ep, 1'($urandom_range(1)), len, {$urandom(), $urandom()});
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        send_command(nat_pkg::CMD_LOOKUP,  8'd0,   8'd0,   1'b0, 4'd0,  '0);
        send_command(nat_pkg::CMD_REMOVE,  8'd0,   8'd0,   1'b0, 4'd0,  '0);
        send_command(nat_pkg::CMD_REM_DEV, 8'd0,   8'd0,   1'b0, 4'd0,  '0);
        send_command(nat_pkg::CMD_ADD,     8'd0,   8'd0,   1'b0, 4'd8,  '1);
        send_command(nat_pkg::CMD_ADD,     8'd0,   8'd0,   1'b1, 4'd15, '1);
        send_command(nat_pkg::CMD_ADD,     8'd255, 8'd255, 1'b1, 4'd9,  '1);
        send_command(nat_pkg::CMD_ADD,     8'd255, 8'd255, 1'b1, 4'd0,  '1);
        send_command(nat_pkg::CMD_LOOKUP,  8'd255, 8'd255, 1'b1, 4'd15, '1);
        send_command(nat_pkg::CMD_ADD,     8'd1,   8'd5,   1'b0, 4'd3,
                     64'h1122_3344_5566_7788);
        send_command(nat_pkg::CMD_LOOKUP,  8'd1,   8'd5,   1'b0, 4'd0,  '0);
        send_command(nat_pkg::CMD_REMOVE,  8'd1,   8'd5,   1'b1, 4'd0,  '0);
        for (int i = 0; i < 13; i++)
            send_command(nat_pkg::CMD_ADD, 8'd2, 8'(i), 1'($urandom_range(1)),
                         4'($urandom_range(8)), {$urandom(), $urandom()});
        send_command(nat_pkg::CMD_ADD,     8'd3,   8'd0,   1'b0, 4'd2,
                     64'h0000_0000_0000_abcd);
        send_command(nat_pkg::CMD_REM_DEV, 8'd2,   8'd0,   1'b0, 4'd0,  '0);
        send_command(nat_pkg::CMD_REMOVE,  8'd1,   8'd5,   1'b0, 4'd0,  '0);
        send_command(nat_pkg::CMD_LOOKUP,  8'd0,   8'd0,   1'b1, 4'd0,  '0);
        drain_replies();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
                send_random(n);
            drain_replies();
        end

        repeat (40) @(posedge aclk);
        if (table_sb.pending() != 0) begin
            $error("%0d result words never arrived", table_sb.pending());
            table_sb.fails++;
        end
        if (table_sb.fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
rtl/nat_pkg.sv
rtl/nat_store.sv
rtl/neighbour_address_table.sv
sim/neighbour_address_table_test.sv
